// ===== hw/rtl/mmss_pkg.sv =====
// Shared constants, types and helpers for the merged mining slot search.
`timescale 1ns / 1ps

package mmss_pkg;

   localparam int MAX_IDS    = 32;
   localparam int MAX_HEIGHT = 7;

   localparam int ID_W     = 16;
   localparam int ID_AW    = $clog2(MAX_IDS);
   localparam int CNT_W    = $clog2(MAX_IDS + 1);
   localparam int SLOT_W   = MAX_HEIGHT;
   localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);
   localparam int MAP_SIZE = 2 ** MAX_HEIGHT;

   localparam logic [31:0] LCG_MUL = 32'd1103515245;
   localparam logic [31:0] LCG_ADD = 32'd12345;
   // Low bits of x * a + c mod 2^32 depend only on the low bits of x.
   localparam logic [SLOT_W-1:0] LCG_MUL_LO = LCG_MUL[SLOT_W-1:0];
   localparam logic [SLOT_W-1:0] LCG_ADD_LO = LCG_ADD[SLOT_W-1:0];

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_BASE,
      ST_READ,
      ST_TEST,
      ST_OUT_READ,
      ST_SHOW
   } state_type;

   // Leaf mask for a given height, also the largest nonce at that height.
   function automatic logic [SLOT_W-1:0] height_mask(input logic [HEIGHT_W-1:0] h);
      logic [SLOT_W:0] span;
      span = (SLOT_W + 1)'(1) << h;
      return SLOT_W'(span - (SLOT_W + 1)'(1));
   endfunction

   // Smallest h with 2^h >= n; zero for a single ID.
   function automatic logic [HEIGHT_W-1:0] start_height(input logic [CNT_W-1:0] n);
      logic [HEIGHT_W-1:0] h;
      h = '0;
      for (int i = 0; i < MAX_HEIGHT; i++) begin
         if ((32'd1 << i) < 32'(n)) begin
            h = HEIGHT_W'(i + 1);
         end
      end
      return h;
   endfunction

endpackage

// ===== hw/rtl/merged_mining_slot_search.sv =====
// Top level of the merged mining slot search: ID load, trial sequencer, result output.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   req     | in        | req_valid/req_stall | chain_id, last_id
//   rsp     | out       | rsp_valid/rsp_stall | leaf_index, map_nonce, tree_height,
//           |           |                     | found, last_result
//
// IDs load one per cycle while idle. The ID marked last starts the search: a setup step
// picks the start height, then each trial has a base LCG step and, per ID tested, a read
// step (ID memory read) and a test step (the single shared LCG unit and the map check).
// Each result leaves via a slot memory read step, then a show step. req_stall stays high
// from the last ID until the final result is taken. Synchronous reset returns to idle with
// an empty list and a clear map. rsp_stall holds the shown result in place.
`timescale 1ns / 1ps

module merged_mining_slot_search
   import mmss_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ID_W-1:0]     req_chain_id,
   input  logic                req_last_id,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SLOT_W-1:0]   rsp_leaf_index,
   output logic [SLOT_W-1:0]   rsp_map_nonce,
   output logic [HEIGHT_W-1:0] rsp_tree_height,
   output logic                rsp_found,
   output logic                rsp_last_result
);

   state_type state_ff, state_in;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    walk_ptr_ff, walk_ptr_in;
   logic [CNT_W-1:0]    out_ptr_ff, out_ptr_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [SLOT_W-1:0]   nonce_ff, nonce_in;
   logic [SLOT_W-1:0]   base_ff, base_in;
   logic                found_ff, found_in;
   logic [MAP_SIZE-1:0] occupied_ff, occupied_in;

   logic [ID_W-1:0]   id_mem [MAX_IDS];
   logic [SLOT_W-1:0] slot_mem [MAX_IDS];
   logic [ID_W-1:0]   id_rd_ff;
   logic [SLOT_W-1:0] slot_rd_ff;

   logic              req_fire, rsp_fire;
   logic              id_wr_en, id_rd_en, slot_wr_en, slot_rd_en;
   logic [SLOT_W-1:0] lcg_x, lcg_y;
   logic [SLOT_W-1:0] cur_mask, slot;
   logic              collide, walk_done, nonce_done, height_done, out_done;

   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;

   assign cur_mask    = height_mask(height_ff);
   assign slot        = lcg_y & cur_mask;
   assign collide     = occupied_ff[slot];
   assign walk_done   = (walk_ptr_ff + CNT_W'(1)) == count_ff;
   assign nonce_done  = nonce_ff == cur_mask;
   assign height_done = height_ff == HEIGHT_W'(MAX_HEIGHT);
   assign out_done    = (out_ptr_ff + CNT_W'(1)) == count_ff;

   // Base step takes the nonce; test step takes base plus the ID.
   assign lcg_x = (state_ff == ST_BASE) ? nonce_ff : base_ff + id_rd_ff[SLOT_W-1:0];

   mmss_lcg_unit u_lcg (
      .op_x  (lcg_x),
      .lcg_y (lcg_y)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_last_id) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: state_in = ST_BASE;
         ST_BASE:  state_in = ST_READ;
         ST_READ:  state_in = ST_TEST;
         ST_TEST: begin
            if (collide) begin
               if (nonce_done && height_done) begin
                  state_in = ST_SHOW;
               end else begin
                  state_in = ST_BASE;
               end
            end else if (walk_done) begin
               state_in = ST_OUT_READ;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_OUT_READ: state_in = ST_SHOW;
         ST_SHOW: begin
            if (rsp_fire) begin
               state_in = (!found_ff || out_done) ? ST_IDLE : ST_OUT_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and memory strobes
   always_comb begin
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      id_wr_en   = 1'b0;
      id_rd_en   = 1'b0;
      slot_wr_en = 1'b0;
      slot_rd_en = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            id_wr_en  = req_valid && (count_ff < CNT_W'(MAX_IDS));
         end
         ST_READ:     id_rd_en   = 1'b1;
         ST_TEST:     slot_wr_en = !collide;
         ST_OUT_READ: slot_rd_en = 1'b1;
         ST_SHOW:     rsp_valid  = 1'b1;
         default: ;
      endcase
   end

   // Datapath register updates
   always_comb begin
      count_in    = count_ff;
      walk_ptr_in = walk_ptr_ff;
      out_ptr_in  = out_ptr_ff;
      height_in   = height_ff;
      nonce_in    = nonce_ff;
      base_in     = base_ff;
      found_in    = found_ff;
      occupied_in = occupied_ff;
      case (state_ff)
         ST_IDLE: begin
            if (id_wr_en) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         ST_SETUP: begin
            height_in = start_height(count_ff);
            nonce_in  = '0;
         end
         ST_BASE: begin
            base_in     = lcg_y;
            occupied_in = '0;
            walk_ptr_in = '0;
         end
         ST_TEST: begin
            if (collide) begin
               if (nonce_done && height_done) begin
                  found_in = 1'b0;
               end else if (nonce_done) begin
                  height_in = height_ff + HEIGHT_W'(1);
                  nonce_in  = '0;
               end else begin
                  nonce_in = nonce_ff + SLOT_W'(1);
               end
            end else begin
               occupied_in[slot] = 1'b1;
               walk_ptr_in       = walk_ptr_ff + CNT_W'(1);
               if (walk_done) begin
                  found_in   = 1'b1;
                  out_ptr_in = '0;
               end
            end
         end
         ST_SHOW: begin
            if (rsp_fire) begin
               out_ptr_in = out_ptr_ff + CNT_W'(1);
               if (!found_ff || out_done) begin
                  count_in = '0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         walk_ptr_ff <= '0;
         out_ptr_ff  <= '0;
         height_ff   <= '0;
         nonce_ff    <= '0;
         found_ff    <= 1'b0;
         occupied_ff <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         walk_ptr_ff <= walk_ptr_in;
         out_ptr_ff  <= out_ptr_in;
         height_ff   <= height_in;
         nonce_ff    <= nonce_in;
         found_ff    <= found_in;
         occupied_ff <= occupied_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
   end

   always_ff @(posedge clock) begin
      if (id_wr_en) begin
         id_mem[count_ff[ID_AW-1:0]] <= req_chain_id;
      end
      if (id_rd_en) begin
         id_rd_ff <= id_mem[walk_ptr_ff[ID_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (slot_wr_en) begin
         slot_mem[walk_ptr_ff[ID_AW-1:0]] <= slot;
      end
      if (slot_rd_en) begin
         slot_rd_ff <= slot_mem[out_ptr_ff[ID_AW-1:0]];
      end
   end

   assign rsp_leaf_index  = found_ff ? slot_rd_ff : '0;
   assign rsp_map_nonce   = found_ff ? nonce_ff : '0;
   assign rsp_tree_height = found_ff ? height_ff : '0;
   assign rsp_found       = found_ff;
   assign rsp_last_result = !found_ff || out_done;

endmodule

// ===== hw/rtl/mmss_lcg_unit.sv =====
// Shared LCG step unit, reduced to the slot-width low bits.
`timescale 1ns / 1ps

module mmss_lcg_unit
   import mmss_pkg::*;
(
   input  logic [SLOT_W-1:0] op_x,
   output logic [SLOT_W-1:0] lcg_y
);

   logic [2*SLOT_W-1:0] product;

   assign product = (2*SLOT_W)'(op_x) * (2*SLOT_W)'(LCG_MUL_LO);
   assign lcg_y   = product[SLOT_W-1:0] + LCG_ADD_LO;

endmodule

// ===== hw/rtl/mmss_checker.sv =====
// Port-level checker for the merged mining slot search, bound to the top level.
`timescale 1ns / 1ps

module mmss_checker
   import mmss_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [SLOT_W-1:0]   rsp_leaf_index,
   input logic [SLOT_W-1:0]   rsp_map_nonce,
   input logic [HEIGHT_W-1:0] rsp_tree_height,
   input logic                rsp_found,
   input logic                rsp_last_result
);

   // Hold a stalled result transaction.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_leaf_index)
         && $stable(rsp_map_nonce) && $stable(rsp_tree_height)
         && $stable(rsp_found) && $stable(rsp_last_result))
      else $error("stalled result changed");

   // No new ID is taken while results are pending.
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input ready while delivering results");

   // A failure is a single, all-zero, final result.
   a_fail_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last_result && rsp_leaf_index == '0
         && rsp_map_nonce == '0 && rsp_tree_height == '0)
      else $error("malformed failure result");

   // Slot and nonce both fit the chosen height.
   a_fit_height: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> (rsp_leaf_index >> rsp_tree_height) == '0
         && (rsp_map_nonce >> rsp_tree_height) == '0)
      else $error("slot or nonce exceeds tree height");

endmodule

bind merged_mining_slot_search mmss_checker u_mmss_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_leaf_index  (rsp_leaf_index),
   .rsp_map_nonce   (rsp_map_nonce),
   .rsp_tree_height (rsp_tree_height),
   .rsp_found       (rsp_found),
   .rsp_last_result (rsp_last_result)
);

// ===== tb/tb_merged_mining_slot_search.sv =====
// Self-checking testbench for merged_mining_slot_search: chain ID lists in, slot maps checked.
`timescale 1ns / 1ps

module tb_merged_mining_slot_search
   import mmss_pkg::*;
();

   localparam int IDLE_LIMIT  = 100000;
   localparam int DRAIN_TIME  = 200;
   localparam int RAND_ITEMS  = 390;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [ID_W-1:0] chain_id;
      logic            last_id;
      logic            pause_first;
   } id_item_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   leaf;
      logic [SLOT_W-1:0]   nonce;
      logic [HEIGHT_W-1:0] height;
      logic                found;
      logic                last;
   } slot_grant_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [ID_W-1:0]     req_chain_id = '0;
   logic                req_last_id = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [SLOT_W-1:0]   rsp_leaf_index;
   logic [SLOT_W-1:0]   rsp_map_nonce;
   logic [HEIGHT_W-1:0] rsp_tree_height;
   logic                rsp_found;
   logic                rsp_last_result;

   id_item_type    id_feed_q[$];
   slot_grant_type slot_grant_q[$];

   // Predictor copy of the loaded list
   logic [ID_W-1:0] list_ids [MAX_IDS];
   int              list_len = 0;

   int n_fail      = 0;
   int idle_cycles = 0;
   int grants_seen = 0;

   merged_mining_slot_search u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_chain_id    (req_chain_id),
      .req_last_id     (req_last_id),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_leaf_index  (rsp_leaf_index),
      .rsp_map_nonce   (rsp_map_nonce),
      .rsp_tree_height (rsp_tree_height),
      .rsp_found       (rsp_found),
      .rsp_last_result (rsp_last_result)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [31:0] lcg_next(input logic [31:0] x);
      return x * LCG_MUL + LCG_ADD;
   endfunction

   // Search heights and nonces for a collision-free leaf map of the loaded list.
   task automatic solve_slot_map();
      logic [SLOT_W-1:0] slots [MAX_IDS];
      logic [MAP_SIZE-1:0] taken;
      logic [31:0] hash;
      slot_grant_type g;
      int h, nonce, k, mask, slot, best_h, best_n;
      bit hit, ok;
      hit = 0;
      best_h = 0;
      best_n = 0;
      h = 0;
      while (list_len > 1 && (1 << h) < list_len) h++;
      while (!hit && h <= MAX_HEIGHT) begin
         mask = (1 << h) - 1;
         nonce = 0;
         while (!hit && nonce < (1 << h)) begin
            taken = '0;
            ok = 1;
            for (k = 0; k < list_len && ok; k++) begin
               hash = lcg_next(lcg_next(32'(nonce)) + {16'h0000, list_ids[k]});
               slot = int'(hash[SLOT_W-1:0]) & mask;
               if (taken[slot]) begin
                  ok = 0;
               end else begin
                  taken[slot] = 1'b1;
                  slots[k] = SLOT_W'(slot);
               end
            end
            if (ok) begin
               hit = 1;
               best_h = h;
               best_n = nonce;
            end
            nonce++;
         end
         h++;
      end
      if (!hit) begin
         g = '{leaf: '0, nonce: '0, height: '0, found: 1'b0, last: 1'b1};
         slot_grant_q.push_back(g);
      end else begin
         for (k = 0; k < list_len; k++) begin
            g.leaf   = slots[k];
            g.nonce  = SLOT_W'(best_n);
            g.height = HEIGHT_W'(best_h);
            g.found  = 1'b1;
            g.last   = (k == list_len - 1);
            slot_grant_q.push_back(g);
         end
      end
   endtask

   task automatic absorb_id(input logic [ID_W-1:0] id, input logic last);
      if (list_len < MAX_IDS) begin
         list_ids[list_len] = id;
         list_len++;
      end
      if (last) begin
         solve_slot_map();
         list_len = 0;
      end
   endtask

   task automatic push_id(input logic [ID_W-1:0] id, input logic last, input logic pause);
      id_item_type it;
      it.chain_id    = id;
      it.last_id     = last;
      it.pause_first = pause;
      id_feed_q.push_back(it);
   endtask

   // Queue one list; dup repeats an earlier ID as the final entry so the search fails.
   task automatic push_list(input int len, input int max_val, input bit dup, input bit pause);
      logic [ID_W-1:0] ids [64];
      int k;
      for (k = 0; k < len; k++) begin
         ids[k] = ID_W'($urandom_range(0, max_val));
         if (dup && k == len - 1) ids[k] = ids[$urandom_range(0, len - 2)];
         push_id(ids[k], k == len - 1, pause && k == 0);
      end
   endtask

   // Driver
   int send_gap  = 0;
   int send_calm = 0;
   always @(posedge clock) begin
      id_item_type nxt;
      int r;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) absorb_id(req_chain_id, req_last_id);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (id_feed_q.size() != 0 &&
                         !(id_feed_q[0].pause_first && slot_grant_q.size() != 0)) begin
               nxt = id_feed_q.pop_front();
               req_valid    <= 1'b1;
               req_chain_id <= nxt.chain_id;
               req_last_id  <= nxt.last_id;
               if (send_calm > 0) begin
                  send_calm--;
               end else begin
                  r = $urandom_range(0, 99);
                  if (r < 55) send_gap = 0;
                  else if (r < 85) send_gap = $urandom_range(1, 3);
                  else if (r < 95) send_gap = $urandom_range(8, 40);
                  else send_calm = $urandom_range(30, 80);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold, started once enough results have passed
   int  hold_left = 0;
   bit  hold_done = 0;
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && rsp_valid && grants_seen >= 40) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor and receiver stall
   int  stall_left = 0;
   int  recv_calm  = 0;
   always @(posedge clock) begin
      slot_grant_type want;
      int r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            grants_seen++;
            if (slot_grant_q.size() == 0) begin
               $error("unexpected result transaction: leaf_index %0d found %0d",
                      rsp_leaf_index, rsp_found);
               n_fail++;
            end else begin
               want = slot_grant_q.pop_front();
               if (rsp_leaf_index !== want.leaf) begin
                  $error("leaf_index: expected %0d, actual %0d", want.leaf, rsp_leaf_index);
                  n_fail++;
               end
               if (rsp_map_nonce !== want.nonce) begin
                  $error("map_nonce: expected %0d, actual %0d", want.nonce, rsp_map_nonce);
                  n_fail++;
               end
               if (rsp_tree_height !== want.height) begin
                  $error("tree_height: expected %0d, actual %0d", want.height, rsp_tree_height);
                  n_fail++;
               end
               if (rsp_found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_found);
                  n_fail++;
               end
               if (rsp_last_result !== want.last) begin
                  $error("last_result: expected %0d, actual %0d", want.last, rsp_last_result);
                  n_fail++;
               end
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (recv_calm > 0) begin
               recv_calm--;
            end else begin
               r = $urandom_range(0, 99);
               if (r < 25) stall_left = $urandom_range(1, 3);
               else if (r < 29) stall_left = $urandom_range(15, 60);
               else if (r < 33) recv_calm = $urandom_range(40, 120);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      do @(posedge clock); while (idle_cycles < IDLE_LIMIT);
      $error("no transaction for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int r, len, stored, n_long, n_over;
      // Directed lists: single IDs at both extremes, pairs, duplicates, small counts
      push_id(16'h0000, 1'b1, 1'b0);
      push_id(16'hFFFF, 1'b1, 1'b0);
      push_id(16'h0000, 1'b0, 1'b0);
      push_id(16'hFFFF, 1'b1, 1'b0);
      push_id(16'h1234, 1'b0, 1'b1);
      push_id(16'h1234, 1'b1, 1'b0);
      push_id(16'h0001, 1'b0, 1'b0);
      push_id(16'h0002, 1'b0, 1'b0);
      push_id(16'h8000, 1'b1, 1'b0);
      push_id(16'h7FFF, 1'b0, 1'b1);
      push_id(16'h8000, 1'b0, 1'b0);
      push_id(16'hAAAA, 1'b0, 1'b0);
      push_id(16'h5555, 1'b0, 1'b0);
      push_id(16'h00FF, 1'b1, 1'b0);
      for (int k = 0; k < 4; k++) push_id(ID_W'(k), k == 3, 1'b0);

      // Random lists: mostly short, a few full and a few overflowing
      stored = 0;
      n_long = 0;
      n_over = 0;
      push_list(MAX_IDS, 65535, 1'b0, 1'b1);
      stored += MAX_IDS;
      push_list(MAX_IDS + 3, 65535, 1'b0, 1'b0);
      stored += MAX_IDS;
      while (stored < RAND_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 68) begin
            len = $urandom_range(1, 8);
            push_list(len, 65535, 1'b0, $urandom_range(0, 19) == 0);
         end else if (r < 80) begin
            len = $urandom_range(2, 10);
            push_list(len, 65535, 1'b1, 1'b0);
         end else if (r < 90) begin
            len = $urandom_range(2, 6);
            push_list(len, 15, 1'b0, 1'b0);
         end else if (r < 95 && n_long < 3) begin
            len = $urandom_range(17, MAX_IDS);
            n_long++;
            push_list(len, 65535, 1'b0, 1'b0);
         end else if (n_over < 2) begin
            len = $urandom_range(MAX_IDS + 1, MAX_IDS + 6);
            n_over++;
            push_list(len, 65535, 1'b0, 1'b0);
         end else begin
            len = $urandom_range(9, 16);
            push_list(len, 65535, 1'b0, 1'b0);
         end
         stored += (len > MAX_IDS) ? MAX_IDS : len;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (id_feed_q.size() != 0 || req_valid) @(posedge clock);
      while (slot_grant_q.size() != 0) @(posedge clock);
      repeat (DRAIN_TIME) @(posedge clock);
      if (slot_grant_q.size() != 0) begin
         $error("%0d expected results never arrived", slot_grant_q.size());
         n_fail++;
      end
      if (n_fail == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/mmss_pkg.sv
hw/rtl/mmss_lcg_unit.sv
hw/rtl/merged_mining_slot_search.sv
hw/rtl/mmss_checker.sv
tb/tb_merged_mining_slot_search.sv
